FILE: sv/t0_procedure_byte_engine_defines.svh
// ----------------------------------------------------------------------------
// T=0 procedure byte engine assertion macros
// Shared property wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef T0_PROCEDURE_BYTE_ENGINE_DEFINES_SVH
`define T0_PROCEDURE_BYTE_ENGINE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define T0PBE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define T0PBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/t0pbe_pkg.sv
// ----------------------------------------------------------------------------
// T=0 procedure byte engine package
// Item and result types, command, action and error codes, defaults.
// ----------------------------------------------------------------------------
package t0pbe_pkg;

  localparam int unsigned MaxCommandDef    = 260;
  localparam int unsigned MaxProceduresDef = 2048;

  localparam logic [15:0] WaitTicksDef = 16'd1500;
  localparam logic [15:0] NullLimitDef = 16'd32;

  // configuration register indexes
  localparam logic CfgWaitTicks = 1'b0;
  localparam logic CfgNullLimit = 1'b1;

  // input commands
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_SEND_HDR  = 3'd1,
    ACT_SEND_BODY = 3'd2,
    ACT_SEND_ONE  = 3'd3,
    ACT_STORE     = 3'd4,
    ACT_DONE      = 3'd5,
    ACT_ERROR     = 3'd6
  } action_e;

  localparam logic [3:0] ERR_NONE          = 4'd0;
  localparam logic [3:0] ERR_BAD_LENGTH    = 4'd1;
  localparam logic [3:0] ERR_BAD_CASE      = 4'd2;
  localparam logic [3:0] ERR_TMO_PROC      = 4'd3;
  localparam logic [3:0] ERR_NULL_LIMIT    = 4'd4;
  localparam logic [3:0] ERR_NO_ROOM_SW    = 4'd5;
  localparam logic [3:0] ERR_TMO_SW2       = 4'd6;
  localparam logic [3:0] ERR_ACK_AFTER     = 4'd7;
  localparam logic [3:0] ERR_NO_ROOM_LE    = 4'd8;
  localparam logic [3:0] ERR_TMO_BLOCK     = 4'd9;
  localparam logic [3:0] ERR_NACK_SENT     = 4'd10;
  localparam logic [3:0] ERR_NACK_RECV     = 4'd11;
  localparam logic [3:0] ERR_NO_ROOM_ONE   = 4'd12;
  localparam logic [3:0] ERR_TMO_ONE       = 4'd13;
  localparam logic [3:0] ERR_BAD_PROC      = 4'd14;
  localparam logic [3:0] ERR_PROC_LIMIT    = 4'd15;

  localparam logic [7:0] NullByte  = 8'h60;
  localparam logic [7:0] HiNibMask = 8'hF0;
  localparam logic [7:0] Sw1HiA    = 8'h60;
  localparam logic [7:0] Sw1HiB    = 8'h90;
  localparam logic [7:0] InsMask   = 8'h0E;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] ins_code;
    logic [7:0] length_byte;
    logic [8:0] command_length;
    logic [8:0] resp_capacity;
    logic [7:0] card_byte;
  } item_t;

  typedef struct packed {
    action_e    action;
    logic [8:0] offset;
    logic [8:0] count;
    logic [7:0] stored_byte;
    logic [3:0] error_code;
    logic [8:0] resp_length;
  } result_t;

endpackage

FILE: sv/t0pbe_core.sv
// ----------------------------------------------------------------------------
// T=0 procedure byte engine core
// Exchange state and the single-pass classification of one item.
// ----------------------------------------------------------------------------
module t0pbe_core import t0pbe_pkg::*; #(
  parameter int unsigned MAX_COMMAND    = MaxCommandDef,
  parameter int unsigned MAX_PROCEDURES = MaxProceduresDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  item_t       item_i,
  input  logic [15:0] wait_ticks_i,
  input  logic [15:0] null_limit_i,
  output result_t     res_o
);

  localparam int unsigned PcW = $clog2(MAX_PROCEDURES + 1);
  localparam logic [8:0]     MaxCmd  = 9'(MAX_COMMAND);
  localparam logic [PcW-1:0] MaxProc = PcW'(MAX_PROCEDURES);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PROC  = 3'd1,
    PH_SW2   = 3'd2,
    PH_BLOCK = 3'd3,
    PH_ONE   = 3'd4
  } phase_e;

  phase_e         phase_q, phase_d;
  logic [7:0]     ins_q, ins_d;
  logic           case3_q, case3_d;
  logic [8:0]     exp_q, exp_d;
  logic [8:0]     cap_q, cap_d;
  logic [8:0]     rcv_q, rcv_d;
  logic [7:0]     sent_q, sent_d;
  logic [15:0]    null_q, null_d;
  logic [15:0]    wait_q, wait_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic [8:0]     rem_q, rem_d;

  logic [15:0] wlim, nlim;
  logic [16:0] wait_inc, null_inc;
  logic        c2, c3, bad_len, is_sw1, is_ack, is_nack;
  logic [7:0]  b, p3;
  logic [8:0]  clen, cap, rem_dec;

  assign wlim     = (wait_ticks_i != '0) ? wait_ticks_i : WaitTicksDef;
  assign nlim     = (null_limit_i != '0) ? null_limit_i : NullLimitDef;
  assign wait_inc = {1'b0, wait_q} + 17'd1;
  assign null_inc = {1'b0, null_q} + 17'd1;
  assign b        = item_i.card_byte;
  assign p3       = item_i.length_byte;
  assign clen     = item_i.command_length;
  assign cap      = item_i.resp_capacity;
  assign bad_len  = (clen < 9'd5) || (clen > MaxCmd) || (cap < 9'd2);
  assign c2       = (clen == 9'd5);
  assign c3       = (p3 != '0) && (clen == ({1'b0, p3} + 9'd5));
  assign is_sw1   = ((b & HiNibMask) == Sw1HiA) || ((b & HiNibMask) == Sw1HiB);
  assign is_ack   = (b & InsMask) == (ins_q & InsMask);
  assign is_nack  = (b & InsMask) == (~ins_q & InsMask);
  assign rem_dec  = (rem_q != '0) ? rem_q - 9'd1 : rem_q;

  always_comb begin
    res_o   = '0;
    phase_d = phase_q;
    ins_d   = ins_q;
    case3_d = case3_q;
    exp_d   = exp_q;
    cap_d   = cap_q;
    rcv_d   = rcv_q;
    sent_d  = sent_q;
    null_d  = null_q;
    wait_d  = wait_q;
    pc_d    = pc_q;
    rem_d   = rem_q;

    if (item_i.cmd == CMD_START) begin
      if (bad_len) begin
        res_o.action     = ACT_ERROR;
        res_o.error_code = ERR_BAD_LENGTH;
        phase_d          = PH_IDLE;
      end else if (!c2 && !c3) begin
        res_o.action     = ACT_ERROR;
        res_o.error_code = ERR_BAD_CASE;
        phase_d          = PH_IDLE;
      end else begin
        ins_d   = item_i.ins_code;
        case3_d = c3;
        exp_d   = (c3 || p3 != '0) ? {1'b0, p3} : 9'd256;
        cap_d   = cap;
        rcv_d   = '0;
        sent_d  = '0;
        null_d  = '0;
        wait_d  = '0;
        pc_d    = '0;
        rem_d   = '0;
        phase_d = PH_PROC;
        res_o.action = ACT_SEND_HDR;
        res_o.count  = 9'd5;
      end
    end else if (item_i.cmd != CMD_BYTE && item_i.cmd != CMD_TICK) begin
      res_o.action = ACT_NONE;
    end else if (phase_q == PH_IDLE) begin
      res_o.action = ACT_NONE;
    end else if (phase_q == PH_PROC && pc_q >= MaxProc) begin
      res_o.action     = ACT_ERROR;
      res_o.error_code = ERR_PROC_LIMIT;
      phase_d          = PH_IDLE;
    end else if (item_i.cmd == CMD_TICK) begin
      wait_d = wait_inc[15:0];
      if (wait_inc >= {1'b0, wlim}) begin
        res_o.action = ACT_ERROR;
        phase_d      = PH_IDLE;
        case (phase_q)
          PH_PROC:  res_o.error_code = ERR_TMO_PROC;
          PH_SW2:   res_o.error_code = ERR_TMO_SW2;
          PH_BLOCK: res_o.error_code = ERR_TMO_BLOCK;
          default:  res_o.error_code = ERR_TMO_ONE;
        endcase
      end
    end else begin
      wait_d = '0;
      case (phase_q)
        PH_PROC: begin
          pc_d = pc_q + PcW'(1);
          if (b == NullByte) begin
            null_d = null_inc[15:0];
            if (null_inc >= {1'b0, nlim}) begin
              res_o.action     = ACT_ERROR;
              res_o.error_code = ERR_NULL_LIMIT;
              phase_d          = PH_IDLE;
            end
          end else if (is_sw1) begin
            if (({1'b0, rcv_q} + 10'd2) > {1'b0, cap_q}) begin
              res_o.action     = ACT_ERROR;
              res_o.error_code = ERR_NO_ROOM_SW;
              phase_d          = PH_IDLE;
            end else begin
              res_o.action      = ACT_STORE;
              res_o.offset      = rcv_q;
              res_o.stored_byte = b;
              rcv_d             = rcv_q + 9'd1;
              phase_d           = PH_SW2;
            end
          end else if (is_ack) begin
            null_d = '0;
            if (case3_q) begin
              if (sent_q != '0 || exp_q == '0) begin
                res_o.action     = ACT_ERROR;
                res_o.error_code = ERR_ACK_AFTER;
                phase_d          = PH_IDLE;
              end else begin
                sent_d       = exp_q[7:0];
                res_o.action = ACT_SEND_BODY;
                res_o.offset = 9'd5;
                res_o.count  = exp_q;
              end
            end else if (({1'b0, rcv_q} + {1'b0, exp_q} + 10'd2) > {1'b0, cap_q}) begin
              res_o.action     = ACT_ERROR;
              res_o.error_code = ERR_NO_ROOM_LE;
              phase_d          = PH_IDLE;
            end else begin
              rem_d   = exp_q;
              phase_d = PH_BLOCK;
            end
          end else if (is_nack) begin
            null_d = '0;
            if (case3_q) begin
              if ({1'b0, sent_q} >= exp_q) begin
                res_o.action     = ACT_ERROR;
                res_o.error_code = ERR_NACK_SENT;
                phase_d          = PH_IDLE;
              end else begin
                res_o.action = ACT_SEND_ONE;
                res_o.offset = 9'd5 + {1'b0, sent_q};
                res_o.count  = 9'd1;
                sent_d       = sent_q + 8'd1;
              end
            end else if (rcv_q >= exp_q) begin
              res_o.action     = ACT_ERROR;
              res_o.error_code = ERR_NACK_RECV;
              phase_d          = PH_IDLE;
            end else if (({1'b0, rcv_q} + 10'd1) > {1'b0, cap_q}) begin
              res_o.action     = ACT_ERROR;
              res_o.error_code = ERR_NO_ROOM_ONE;
              phase_d          = PH_IDLE;
            end else begin
              phase_d = PH_ONE;
            end
          end else begin
            res_o.action     = ACT_ERROR;
            res_o.error_code = ERR_BAD_PROC;
            phase_d          = PH_IDLE;
          end
        end
        PH_SW2: begin
          res_o.action      = ACT_DONE;
          res_o.offset      = rcv_q;
          res_o.stored_byte = b;
          res_o.resp_length = rcv_q + 9'd1;
          phase_d           = PH_IDLE;
        end
        PH_BLOCK: begin
          res_o.action      = ACT_STORE;
          res_o.offset      = rcv_q;
          res_o.stored_byte = b;
          rcv_d             = rcv_q + 9'd1;
          rem_d             = rem_dec;
          if (rem_dec == '0) begin
            phase_d = PH_PROC;
          end
        end
        default: begin
          res_o.action      = ACT_STORE;
          res_o.offset      = rcv_q;
          res_o.stored_byte = b;
          rcv_d             = rcv_q + 9'd1;
          phase_d           = PH_PROC;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      ins_q   <= '0;
      case3_q <= 1'b0;
      exp_q   <= '0;
      cap_q   <= '0;
      rcv_q   <= '0;
      sent_q  <= '0;
      null_q  <= '0;
      wait_q  <= '0;
      pc_q    <= '0;
      rem_q   <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      ins_q   <= ins_d;
      case3_q <= case3_d;
      exp_q   <= exp_d;
      cap_q   <= cap_d;
      rcv_q   <= rcv_d;
      sent_q  <= sent_d;
      null_q  <= null_d;
      wait_q  <= wait_d;
      pc_q    <= pc_d;
      rem_q   <= rem_d;
    end
  end

endmodule

FILE: sv/t0_procedure_byte_engine.sv
// ----------------------------------------------------------------------------
// T=0 procedure byte engine
// Smart-card T=0 exchange controller: header, procedure bytes, status words.
// ----------------------------------------------------------------------------
// The engine takes one item per clock while in_stall_o is low and returns
// exactly one result item for each: an input register captures the item,
// the core classifies it against the exchange state in one pass, and a
// result register holds the answer until the consumer takes it. A start item
// checks the lengths, decides whether the card returns Le bytes or takes an
// Lc body, and asks for the 5-byte header; each card byte is then handled as
// NULL, SW1/SW2, ACK or NACK, and tick items count the card wait time. The
// host moves the actual bytes at the offset and count given in each result.
// Throughput is one item per cycle while the consumer does not stall, set by
// the single state update in the core; there is no start-up sweep after reset.
// Write the configuration registers only while no exchange is in flight.
module t0_procedure_byte_engine import t0pbe_pkg::*; #(
  parameter int unsigned MAX_COMMAND    = MaxCommandDef,
  parameter int unsigned MAX_PROCEDURES = MaxProceduresDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input item channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  ins_code_i,
  input  logic [7:0]  length_byte_i,
  input  logic [8:0]  command_length_i,
  input  logic [8:0]  resp_capacity_i,
  input  logic [7:0]  card_byte_i,
  // result item channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [8:0]  offset_o,
  output logic [8:0]  count_o,
  output logic [7:0]  stored_byte_o,
  output logic [3:0]  error_code_o,
  output logic [8:0]  resp_length_o
);

  logic [15:0] wait_ticks_q, null_limit_q;
  logic        in_vld_q, in_vld_d;
  item_t       in_q;
  logic        out_vld_q, out_vld_d;
  result_t     out_q;
  result_t     core_res;
  logic        in_acc, adv, fire;

  // Config registers: plain writes, no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_ticks_q <= WaitTicksDef;
      null_limit_q <= NullLimitDef;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgWaitTicks: wait_ticks_q <= cfg_data_i;
        CfgNullLimit: null_limit_q <= cfg_data_i;
        default:      wait_ticks_q <= wait_ticks_q;
      endcase
    end
  end

  // The input stage moves on whenever the result register is empty or drains.
  assign adv        = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && adv;
  assign in_stall_o = in_vld_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Hold the item while the stage is blocked, drop the valid once it leaves.
  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  // Result register: load on fire, hold while the consumer stalls.
  always_comb begin
    out_vld_d = out_vld_q && out_stall_i;
    if (fire) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q.cmd            <= cmd_i;
      in_q.ins_code       <= ins_code_i;
      in_q.length_byte    <= length_byte_i;
      in_q.command_length <= command_length_i;
      in_q.resp_capacity  <= resp_capacity_i;
      in_q.card_byte      <= card_byte_i;
    end
    if (fire) begin
      out_q <= core_res;
    end
  end

  t0pbe_core #(
    .MAX_COMMAND    (MAX_COMMAND),
    .MAX_PROCEDURES (MAX_PROCEDURES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (fire),
    .item_i       (in_q),
    .wait_ticks_i (wait_ticks_q),
    .null_limit_i (null_limit_q),
    .res_o        (core_res)
  );

  assign out_valid_o   = out_vld_q;
  assign action_o      = out_q.action;
  assign offset_o      = out_q.offset;
  assign count_o       = out_q.count;
  assign stored_byte_o = out_q.stored_byte;
  assign error_code_o  = out_q.error_code;
  assign resp_length_o = out_q.resp_length;

endmodule

FILE: sv/t0pbe_checker.sv
// ----------------------------------------------------------------------------
// T=0 procedure byte engine checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "t0_procedure_byte_engine_defines.svh"

module t0pbe_checker import t0pbe_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  action_o,
  input logic [8:0]  offset_o,
  input logic [8:0]  count_o,
  input logic [3:0]  error_code_o,
  input logic [8:0]  resp_length_o
);

  `T0PBE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(action_o) && $stable(offset_o), "stalled result changed")
  `T0PBE_ASSERT_SAME(a_err_code, out_valid_o, (action_o == ACT_ERROR) == (error_code_o != ERR_NONE), "error code and action disagree")
  `T0PBE_ASSERT_SAME(a_done_len, out_valid_o && action_o == ACT_DONE, resp_length_o == offset_o + 9'd1, "done length not SW2 index plus one")
  `T0PBE_ASSERT_SAME(a_hdr, out_valid_o && action_o == ACT_SEND_HDR, count_o == 9'd5 && offset_o == 9'd0, "header send not five bytes at zero")

endmodule

bind t0_procedure_byte_engine t0pbe_checker u_chk (.*);

FILE: sim/t0pbe_exchange_checker.sv
// ----------------------------------------------------------------------------
// T=0 exchange checker
// Watches both item channels and the register port of the procedure byte
// engine, predicts each result from its own copy of the exchange state and
// compares it field by field with what the engine returns.
// ----------------------------------------------------------------------------
module t0pbe_exchange_checker import t0pbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  ins_code_i,
  input  logic [7:0]  length_byte_i,
  input  logic [8:0]  command_length_i,
  input  logic [8:0]  resp_capacity_i,
  input  logic [7:0]  card_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  action_i,
  input  logic [8:0]  offset_i,
  input  logic [8:0]  count_i,
  input  logic [7:0]  stored_byte_i,
  input  logic [3:0]  error_code_i,
  input  logic [8:0]  resp_length_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [8:0] HeaderBytes = 9'd5;
  localparam logic [8:0] LeWhenZero  = 9'd256;

  typedef enum logic [2:0] {
    XP_IDLE,
    XP_PROC,
    XP_SW2,
    XP_BLOCK,
    XP_ONE
  } xchg_phase_e;

  // register copies
  logic [15:0] wait_ticks_q;
  logic [15:0] null_limit_q;

  // exchange state
  xchg_phase_e ph;
  logic [7:0]  saved_ins;
  logic        case3;
  logic [8:0]  exp_len;
  logic [8:0]  room;
  logic [8:0]  rcv_cnt;
  logic [7:0]  sent_cnt;
  logic [15:0] null_cnt;
  logic [15:0] wait_cnt;
  logic [11:0] proc_cnt;  // reaches the limit itself, one bit past 2047
  logic [8:0]  blk_left;

  result_t     answers_due[$];
  result_t     want;
  int unsigned mismatches = 0;

  function automatic result_t abort_exchange(input logic [3:0] code);
    result_t r;
    r            = '0;
    r.action     = ACT_ERROR;
    r.error_code = code;
    ph           = XP_IDLE;
    return r;
  endfunction

  function automatic result_t open_exchange(input item_t it);
    result_t r;
    logic    c2;
    logic    c3;
    r = '0;
    if (it.command_length < 5 || it.command_length > MaxCommandDef || it.resp_capacity < 2)
      return abort_exchange(ERR_BAD_LENGTH);
    c2 = (it.command_length == HeaderBytes);
    c3 = (it.length_byte != 0) && (it.command_length == it.length_byte + 5);
    if (!c2 && !c3) return abort_exchange(ERR_BAD_CASE);
    saved_ins = it.ins_code;
    case3     = c3;
    exp_len   = (c3 || it.length_byte != 0) ? {1'b0, it.length_byte} : LeWhenZero;
    room      = it.resp_capacity;
    rcv_cnt   = '0;
    sent_cnt  = '0;
    null_cnt  = '0;
    wait_cnt  = '0;
    proc_cnt  = '0;
    blk_left  = '0;
    ph        = XP_PROC;
    r.action  = ACT_SEND_HDR;
    r.count   = HeaderBytes;
    return r;
  endfunction

  function automatic result_t classify_procedure(input logic [7:0] b);
    result_t     r;
    logic [15:0] nlim;
    r        = '0;
    nlim     = (null_limit_q != 0) ? null_limit_q : NullLimitDef;
    proc_cnt = proc_cnt + 12'd1;
    if (b == NullByte) begin
      null_cnt = null_cnt + 16'd1;
      if (null_cnt >= nlim) return abort_exchange(ERR_NULL_LIMIT);
      return r;
    end
    if ((b & HiNibMask) == Sw1HiA || (b & HiNibMask) == Sw1HiB) begin
      if (rcv_cnt + 2 > room) return abort_exchange(ERR_NO_ROOM_SW);
      r.action      = ACT_STORE;
      r.offset      = rcv_cnt;
      r.stored_byte = b;
      rcv_cnt       = rcv_cnt + 9'd1;
      ph            = XP_SW2;
      return r;
    end
    if ((b & InsMask) == (saved_ins & InsMask)) begin
      null_cnt = '0;
      if (case3) begin
        if (sent_cnt != 0 || exp_len == 0) return abort_exchange(ERR_ACK_AFTER);
        sent_cnt = exp_len[7:0];
        r.action = ACT_SEND_BODY;
        r.offset = HeaderBytes;
        r.count  = exp_len;
        return r;
      end
      if (rcv_cnt + exp_len + 2 > room) return abort_exchange(ERR_NO_ROOM_LE);
      blk_left = exp_len;
      ph       = XP_BLOCK;
      return r;
    end
    if ((b & InsMask) == (~saved_ins & InsMask)) begin
      null_cnt = '0;
      if (case3) begin
        if (sent_cnt >= exp_len) return abort_exchange(ERR_NACK_SENT);
        r.action = ACT_SEND_ONE;
        r.offset = HeaderBytes + sent_cnt;
        r.count  = 9'd1;
        sent_cnt = sent_cnt + 8'd1;
        return r;
      end
      if (rcv_cnt >= exp_len) return abort_exchange(ERR_NACK_RECV);
      if (rcv_cnt + 1 > room) return abort_exchange(ERR_NO_ROOM_ONE);
      ph = XP_ONE;
      return r;
    end
    return abort_exchange(ERR_BAD_PROC);
  endfunction

  function automatic result_t engine_answer(input item_t it);
    result_t     r;
    logic [15:0] wlim;
    r    = '0;
    wlim = (wait_ticks_q != 0) ? wait_ticks_q : WaitTicksDef;
    if (it.cmd == CMD_START) return open_exchange(it);
    if ((it.cmd != CMD_BYTE && it.cmd != CMD_TICK) || ph == XP_IDLE) return r;
    if (ph == XP_PROC && proc_cnt >= MaxProceduresDef) return abort_exchange(ERR_PROC_LIMIT);
    if (it.cmd == CMD_TICK) begin
      wait_cnt = wait_cnt + 16'd1;
      if (wait_cnt >= wlim) begin
        case (ph)
          XP_PROC:  return abort_exchange(ERR_TMO_PROC);
          XP_SW2:   return abort_exchange(ERR_TMO_SW2);
          XP_BLOCK: return abort_exchange(ERR_TMO_BLOCK);
          default:  return abort_exchange(ERR_TMO_ONE);
        endcase
      end
      return r;
    end
    wait_cnt = '0;
    if (ph == XP_PROC) return classify_procedure(it.card_byte);
    if (ph == XP_SW2) begin
      r.action      = ACT_DONE;
      r.offset      = rcv_cnt;
      r.stored_byte = it.card_byte;
      r.resp_length = rcv_cnt + 9'd1;
      ph            = XP_IDLE;
      return r;
    end
    r.action      = ACT_STORE;
    r.offset      = rcv_cnt;
    r.stored_byte = it.card_byte;
    rcv_cnt       = rcv_cnt + 9'd1;
    if (ph == XP_BLOCK) begin
      if (blk_left > 0) blk_left = blk_left - 9'd1;
      if (blk_left == 0) ph = XP_PROC;
    end else begin
      ph = XP_PROC;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [8:0] exp_v,
                             input logic [8:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_ticks_q = WaitTicksDef;
      null_limit_q = NullLimitDef;
      ph           = XP_IDLE;
      saved_ins    = '0;
      case3        = 1'b0;
      exp_len      = '0;
      room         = '0;
      rcv_cnt      = '0;
      sent_cnt     = '0;
      null_cnt     = '0;
      wait_cnt     = '0;
      proc_cnt     = '0;
      blk_left     = '0;
      answers_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgWaitTicks) wait_ticks_q = cfg_data_i;
        else null_limit_q = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (answers_due.size() == 0) begin
          $display("%0t: result with nothing expected: expected none, actual action %0d",
                   $time, action_i);
          mismatches++;
        end else begin
          want = answers_due.pop_front();
          check_field("action", 9'(want.action), 9'(action_i));
          check_field("offset", want.offset, offset_i);
          check_field("count", want.count, count_i);
          check_field("stored_byte", 9'(want.stored_byte), 9'(stored_byte_i));
          check_field("error_code", 9'(want.error_code), 9'(error_code_i));
          check_field("resp_length", want.resp_length, resp_length_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        answers_due.push_back(engine_answer({cmd_i, ins_code_i, length_byte_i,
                                             command_length_i, resp_capacity_i,
                                             card_byte_i}));
      pending_o    <= answers_due.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// T=0 procedure byte engine testbench
// Drives start, card byte and tick items into the engine with bursty input
// and patterned result stalls; a checker beside the engine predicts and
// compares every result. Covers directed corner cases, random exchanges under
// several register settings and a run up to the default NULL limit.
// ----------------------------------------------------------------------------
module testbench;
  import t0pbe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CmdReserved = 2'd3;  // not a command, engine ignores it
  localparam logic [8:0] HeaderBytes = 9'd5;
  localparam int unsigned RandomItems = 480;
  localparam int unsigned SettingCount = 6;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit = 1_000_000;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        cfg_we_i         = 1'b0;
  logic        cfg_index_i      = 1'b0;
  logic [15:0] cfg_data_i       = '0;
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i            = CMD_TICK;
  logic [7:0]  ins_code_i       = '0;
  logic [7:0]  length_byte_i    = '0;
  logic [8:0]  command_length_i = '0;
  logic [8:0]  resp_capacity_i  = '0;
  logic [7:0]  card_byte_i      = '0;
  logic        out_valid_o;
  logic        out_stall_i      = 1'b0;
  logic [2:0]  action_o;
  logic [8:0]  offset_o;
  logic [8:0]  count_o;
  logic [7:0]  stored_byte_o;
  logic [3:0]  error_code_o;
  logic [8:0]  resp_length_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned cycles     = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;

  t0_procedure_byte_engine dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .ins_code_i       (ins_code_i),
    .length_byte_i    (length_byte_i),
    .command_length_i (command_length_i),
    .resp_capacity_i  (resp_capacity_i),
    .card_byte_i      (card_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .action_o         (action_o),
    .offset_o         (offset_o),
    .count_o          (count_o),
    .stored_byte_o    (stored_byte_o),
    .error_code_o     (error_code_o),
    .resp_length_o    (resp_length_o)
  );

  t0pbe_exchange_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .cmd_i            (cmd_i),
    .ins_code_i       (ins_code_i),
    .length_byte_i    (length_byte_i),
    .command_length_i (command_length_i),
    .resp_capacity_i  (resp_capacity_i),
    .card_byte_i      (card_byte_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .action_i         (action_o),
    .offset_i         (offset_o),
    .count_i          (count_o),
    .stored_byte_i    (stored_byte_o),
    .error_code_i     (error_code_o),
    .resp_length_i    (resp_length_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("** t0_procedure_byte_engine: FAILED **");
      $finish;
    end
  end

  // Result-side backpressure: switch between free flow, light random stalls,
  // heavy random stalls and a periodic pattern, so that stalls land on every
  // phase of the exchange.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 9) < 7);
      default: out_stall_i <= stall_left[2];
    endcase
  end

  // Present one item and hold it until the engine takes it. Before a new
  // burst, drop valid for a random gap (or none, so bursts sometimes merge).
  task automatic push_item(input item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i       <= 1'b1;
    cmd_i            <= it.cmd;
    ins_code_i       <= it.ins_code;
    length_byte_i    <= it.length_byte;
    command_length_i <= it.command_length;
    resp_capacity_i  <= it.resp_capacity;
    card_byte_i      <= it.card_byte;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Fields that the command does not use carry random values.
  function automatic item_t filler_item(input logic [1:0] cmd);
    item_t it;
    it.cmd            = cmd;
    it.ins_code       = 8'($urandom);
    it.length_byte    = 8'($urandom);
    it.command_length = 9'($urandom);
    it.resp_capacity  = 9'($urandom);
    it.card_byte      = 8'($urandom);
    return it;
  endfunction

  function automatic item_t start_item(input logic [7:0] ins, input logic [7:0] p3,
                                       input logic [8:0] clen, input logic [8:0] cap);
    item_t it;
    it                = filler_item(CMD_START);
    it.ins_code       = ins;
    it.length_byte    = p3;
    it.command_length = clen;
    it.resp_capacity  = cap;
    return it;
  endfunction

  task automatic card(input logic [7:0] b);
    item_t it;
    it           = filler_item(CMD_BYTE);
    it.card_byte = b;
    push_item(it);
  endtask

  task automatic tick_run(input int unsigned n);
    repeat (n) push_item(filler_item(CMD_TICK));
  endtask

  // High nibble for ACK/NACK bytes: keep clear of NULL and status words.
  function automatic logic [3:0] plain_nibble();
    logic [3:0] hi;
    hi = 4'($urandom_range(0, 15));
    while (hi == 4'h6 || hi == 4'h9) hi = 4'($urandom_range(0, 15));
    return hi;
  endfunction

  function automatic logic [7:0] ack_byte(input logic [7:0] ins);
    logic b0;
    b0 = 1'($urandom_range(0, 1));
    return {plain_nibble(), ins[3:1], b0};
  endfunction

  function automatic logic [7:0] nack_byte(input logic [7:0] ins);
    logic b0;
    b0 = 1'($urandom_range(0, 1));
    return {plain_nibble(), ~ins[3:1], b0};
  endfunction

  function automatic logic [7:0] sw1_byte();
    logic [3:0] lo;
    logic       nine;
    nine = 1'($urandom_range(0, 1));
    lo   = nine ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 15));
    return {nine ? Sw1HiB[7:4] : Sw1HiA[7:4], lo};
  endfunction

  // Write both registers on back-to-back edges; engine must be idle.
  task automatic write_settings(input logic [15:0] wait_lim, input logic [15:0] null_lim);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgWaitTicks;
    cfg_data_i  <= wait_lim;
    @(posedge clk_i);
    cfg_index_i <= CfgNullLimit;
    cfg_data_i  <= null_lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop sending, wait until every predicted result has come back, then keep idle
  // so that nothing is still inside the pipeline.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One random exchange. Most are well formed with random content: a valid
  // case 2 or case 3 header, a string of NULL/ACK/NACK bytes with data and
  // ticks mixed in, then SW1 and SW2. The rest are bad headers and noise.
  task automatic random_exchange();
    logic [7:0]  ins;
    logic [7:0]  p3;
    logic [8:0]  cap;
    int unsigned le;
    int unsigned steps;
    int unsigned pick;
    int unsigned k;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      push_item(filler_item(2'($urandom)));
      return;
    end
    if (pick < 12) begin
      push_item(start_item(8'($urandom), 8'($urandom), 9'($urandom), 9'($urandom)));
      return;
    end
    ins   = 8'($urandom);
    steps = $urandom_range(0, 7);
    if (pick < 55) begin
      // case 3: body goes out by ACK (all at once) or NACK (byte by byte)
      p3  = ($urandom_range(0, 24) == 0) ? 8'($urandom_range(1, 255))
                                         : 8'($urandom_range(1, 6));
      cap = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(2, 511))
                                        : 9'($urandom_range(2, 10));
      push_item(start_item(ins, p3, {1'b0, p3} + 9'd5, cap));
      repeat (steps) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) card(NullByte);
        else if (pick < 60) card(nack_byte(ins));
        else if (pick < 75) card(ack_byte(ins));
        else if (pick < 92) tick_run($urandom_range(1, 6));
        else card(8'($urandom));
      end
    end else begin
      // case 2: Le bytes come in by ACK (block) or NACK (single byte)
      p3  = ($urandom_range(0, 29) == 0) ? 8'h00 : 8'($urandom_range(1, 6));
      le  = (p3 == 0) ? 256 : p3;
      cap = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(2, le + 2))
                                        : 9'(le + 2 + $urandom_range(0, 4));
      push_item(start_item(ins, p3, HeaderBytes, cap));
      repeat (steps) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          card(NullByte);
        end else if (pick < 50) begin
          card(nack_byte(ins));
          if ($urandom_range(0, 9) == 0) tick_run(1);
          card(8'($urandom));
        end else if (pick < 70) begin
          card(ack_byte(ins));
          for (k = 0; k < le; k++) begin
            if ($urandom_range(0, 9) == 0) tick_run(1);
            card(8'($urandom));
          end
        end else if (pick < 88) begin
          tick_run($urandom_range(1, 6));
        end else begin
          card(8'($urandom));
        end
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      card(sw1_byte());
      if ($urandom_range(0, 7) == 0) tick_run($urandom_range(1, 4));
      card(8'($urandom));
    end
  endtask

  initial begin
    logic [15:0] wait_lim;
    logic [15:0] null_lim;
    int unsigned setting;
    int unsigned target;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed corners, reset register values ----
    // idle engine ignores card bytes, ticks and the reserved command
    tick_run(1);
    card(8'hFF);
    push_item(filler_item(CmdReserved));
    // length checks: too short, too long, no response room, all bits set
    push_item(start_item(8'h00, 8'h00, 9'd4, 9'd2));
    push_item(start_item(8'hFF, 8'hFF, 9'd261, 9'd511));
    push_item(start_item(8'h12, 8'h00, 9'd5, 9'd1));
    push_item(start_item(8'hFF, 8'hFF, 9'd511, 9'd511));
    // neither case 2 nor case 3
    push_item(start_item(8'h20, 8'h03, 9'd7, 9'd16));
    push_item(start_item(8'h20, 8'h00, 9'd6, 9'd16));
    // longest case 3 body: NULL, one byte by NACK, then ACK after sending
    push_item(start_item(8'hA4, 8'hFF, 9'd260, 9'd2));
    card(NullByte);
    card(8'h0A);
    card(8'hA4);
    // case 2 restarted while busy, then NACK byte, ACK block, SW1 SW2
    push_item(start_item(8'hB0, 8'h02, HeaderBytes, 9'd5));
    push_item(start_item(8'hB0, 8'h02, HeaderBytes, 9'd5));
    card(8'h0E);
    card(8'h00);
    card(8'hB1);
    card(8'hFF);
    tick_run(1);
    card(8'h5A);
    card(8'h61);
    card(8'h00);
    // Le of zero means 256; a byte that is no procedure byte aborts
    push_item(start_item(8'h00, 8'h00, HeaderBytes, 9'd258));
    card(8'h02);
    drain_results();

    // ---- random exchanges under several register settings ----
    target = RandomItems / SettingCount;
    for (setting = 0; setting < SettingCount; setting++) begin
      case (setting)
        0:       begin wait_lim = 16'd1;      null_lim = 16'd1;      end
        1:       begin wait_lim = 16'd3;      null_lim = 16'd2;      end
        2:       begin wait_lim = 16'd0;      null_lim = 16'd0;      end
        3:       begin wait_lim = 16'hFFFF;   null_lim = 16'hFFFF;   end
        default: begin
          wait_lim = 16'($urandom_range(2, 8));
          null_lim = 16'($urandom_range(2, 8));
        end
      endcase
      write_settings(wait_lim, null_lim);
      items_sent = 0;
      while (items_sent < target) random_exchange();
      drain_results();
    end

    // ---- zero registers fall back to defaults: the 32nd NULL byte aborts ----
    write_settings(16'd0, 16'd0);
    push_item(start_item(8'h5C, 8'h01, HeaderBytes, 9'd8));
    repeat (32) card(NullByte);
    drain_results();

    if (fail_count == 0) begin
      $display("** t0_procedure_byte_engine: PASSED **");
    end else begin
      $display("** t0_procedure_byte_engine: FAILED **");
    end
    $finish;
  end

endmodule
